>>> rtl/lcs_pkg.sv
// shared types and constants for the lcs traceback core
`timescale 1ns / 1ps
package lcs_pkg;
    typedef enum logic [1:0] {
        CMD_APPEND_A = 2'd0,
        CMD_APPEND_B = 2'd1,
        CMD_COMPUTE  = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_MATCH = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_NONE  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_TRACE,
        ST_TWAIT,
        ST_EMIT
    } state_t;
endpackage

>>> rtl/lcs_with_traceback_core.sv
// top level: loads strings, fills the table with a row of cells, traces back and emits
`timescale 1ns / 1ps
// Append commands keep busy low. A compute command fills the table row by
// row. For each row the row's symbol of the first string is first fetched
// through the memory read and the row symbol register, then the column cells
// step one after another, one per cycle, each taking the new and the previous
// length of its left neighbor. Empty strings skip the fill. Traceback then
// walks the direction memory one step at a time (registered read), at most
// rows + cols - 1 steps. Results then come out one per cycle, read from the
// result memory and registered (the empty result skips the memory read).
// Results cannot be stalled: each appears with valid for one cycle. busy is
// high from the compute request until the last emit step, so it may fall
// before the last result appears; a request accepted then does not disturb
// the results still on their way out.
module lcs_with_traceback_core #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] symbol,
    output logic       valid,
    output logic [7:0] out_symbol,
    output logic       last,
    output logic       empty_res,
    output logic       overflow
);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = 2 * AW;

    lcs_pkg::state_t state_reg, state_next;
    logic [LW-1:0] alen_reg, blen_reg;
    logic          drop_reg;
    logic [LW-1:0] row_reg;      // rows done
    logic [AW-1:0] col_reg;      // cell stepping in this row
    logic [LW-1:0] ti_reg, tj_reg, tn_reg, ek_reg;
    logic          ovf_reg;

    logic accept;
    assign accept = start && !busy;
    logic cmp;
    assign cmp = accept && (lcs_pkg::cmd_t'(command) == lcs_pkg::CMD_COMPUTE);

    // first string memory
    logic          a_we;
    logic [AW-1:0] a_raddr;
    logic [7:0]    a_rdata;
    assign a_we = accept && (lcs_pkg::cmd_t'(command) == lcs_pkg::CMD_APPEND_A)
                  && (alen_reg < LW'(MAX_LEN));

    // row symbol register for the cells
    logic [7:0] arow_reg;
    logic       phase_reg; // fill: symbol fetch cycles

    // cell row
    logic [LW-1:0] clen [MAX_LEN];
    lcs_pkg::dir_t cdir [MAX_LEN];
    logic cstep, cclear;
    assign cclear = cmp;

    // length of each cell before its step in this row, the diagonal of its right neighbor
    logic [LW-1:0] diag_reg [MAX_LEN];

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++)
        begin : g_cell
            logic [LW-1:0] lft, dg;
            if (g == 0)
            begin : g_first
                assign lft = '0;
                assign dg  = '0;
            end
            else
            begin : g_rest
                assign lft = clen[g-1];
                assign dg  = diag_reg[g-1];
            end
            lcs_cell #(.LW(LW)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .clear    (cclear),
                .load     (accept && (lcs_pkg::cmd_t'(command) == lcs_pkg::CMD_APPEND_B)
                           && (blen_reg == LW'(g))),
                .load_sym (symbol),
                .step     (cstep && (col_reg == AW'(g))),
                .active   (LW'(g) < blen_reg),
                .a_sym    (arow_reg),
                .left_len (lft),
                .diag_len (dg),
                .len      (clen[g]),
                .dir      (cdir[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_LEN; k++)
        begin
            if (cstep && (col_reg == AW'(k)))
            begin
                diag_reg[k] <= clen[k];
            end
        end
    end

    // direction memory
    logic          d_we;
    logic [DW-1:0] d_waddr, d_raddr;
    logic [1:0]    d_rdata;
    logic          dwe_reg;
    logic [DW-1:0] dwaddr_reg;
    lcs_pkg::dir_t dwdata_reg;
    lcs_ram #(.WIDTH(2), .DEPTH(1 << DW)) u_dir (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (dwdata_reg),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // result memory
    logic          r_we;
    logic [AW-1:0] r_raddr;
    logic [7:0]    r_rdata;
    lcs_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_res (
        .clk   (clk),
        .we    (r_we),
        .waddr (tn_reg[AW-1:0]),
        .wdata (a_rdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    lcs_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_we ? alen_reg[AW-1:0] : AW'(0)),
        .wdata (symbol),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // fill sequencing: the row symbol is fetched first, then one cell steps per
    // cycle along the row and its direction is registered before it is written
    logic fill_step, row_done;
    logic sweep_reg;
    assign fill_step  = (state_reg == lcs_pkg::ST_FILL) && sweep_reg;
    assign cstep      = fill_step;
    assign d_we       = dwe_reg;
    assign d_waddr    = dwaddr_reg;
    assign row_done   = fill_step && (LW'(col_reg) == LW'(blen_reg - LW'(1)));

    lcs_pkg::dir_t td;
    assign td = lcs_pkg::dir_t'(d_rdata);

    // trace step happens in TWAIT with d_rdata valid for (ti-1, tj-1)
    logic trace_end;
    assign trace_end = (ti_reg == '0) || (tj_reg == '0);

    always_comb
    begin
        a_raddr = row_reg[AW-1:0];
        d_raddr = {AW'(ti_reg - LW'(1)), AW'(tj_reg - LW'(1))};
        r_raddr = AW'(tn_reg - LW'(1) - ek_reg);
        if (state_reg == lcs_pkg::ST_TRACE || state_reg == lcs_pkg::ST_TWAIT)
        begin
            a_raddr = AW'(ti_reg - LW'(1));
        end
    end
    assign r_we = (state_reg == lcs_pkg::ST_TWAIT) && (td == lcs_pkg::DIR_MATCH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcs_pkg::ST_IDLE:
            begin
                if (cmp)
                begin
                    state_next = (alen_reg == '0 || blen_reg == '0)
                                 ? lcs_pkg::ST_TRACE : lcs_pkg::ST_FILL;
                end
            end
            lcs_pkg::ST_FILL:
            begin
                if (row_reg == alen_reg)
                begin
                    state_next = lcs_pkg::ST_TRACE;
                end
            end
            lcs_pkg::ST_TRACE:
            begin
                state_next = trace_end ? lcs_pkg::ST_EMIT : lcs_pkg::ST_TWAIT;
            end
            lcs_pkg::ST_TWAIT: state_next = lcs_pkg::ST_TRACE;
            lcs_pkg::ST_EMIT:
            begin
                if (tn_reg == '0 || ek_reg + LW'(1) == tn_reg)
                begin
                    state_next = lcs_pkg::ST_IDLE;
                end
            end
            default: state_next = lcs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != lcs_pkg::ST_IDLE);
    end

    logic emit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcs_pkg::ST_IDLE;
            alen_reg  <= '0;
            blen_reg  <= '0;
            drop_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= 1'b0;
            sweep_reg <= 1'b0;
            ti_reg    <= '0;
            tj_reg    <= '0;
            tn_reg    <= '0;
            ek_reg    <= '0;
            ovf_reg   <= 1'b0;
            emit_reg  <= 1'b0;
            dwe_reg   <= 1'b0;
            valid     <= 1'b0;
            last      <= 1'b0;
            empty_res <= 1'b0;
            overflow  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid     <= 1'b0;
            emit_reg  <= 1'b0;
            dwe_reg   <= cstep;
            if (accept && lcs_pkg::cmd_t'(command) == lcs_pkg::CMD_APPEND_A)
            begin
                if (alen_reg < LW'(MAX_LEN)) alen_reg <= alen_reg + LW'(1);
                else drop_reg <= 1'b1;
            end
            if (accept && lcs_pkg::cmd_t'(command) == lcs_pkg::CMD_APPEND_B)
            begin
                if (blen_reg < LW'(MAX_LEN)) blen_reg <= blen_reg + LW'(1);
                else drop_reg <= 1'b1;
            end
            if (cmp)
            begin
                row_reg   <= '0;
                col_reg   <= '0;
                phase_reg <= 1'b0;
                sweep_reg <= 1'b0;
                ti_reg    <= alen_reg;
                tj_reg    <= blen_reg;
                tn_reg    <= '0;
                ek_reg    <= '0;
                ovf_reg   <= drop_reg;
            end
            if (state_reg == lcs_pkg::ST_FILL)
            begin
                if (!sweep_reg)
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) sweep_reg <= 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + AW'(1);
                    if (row_done)
                    begin
                        col_reg   <= '0;
                        sweep_reg <= 1'b0;
                        row_reg   <= row_reg + LW'(1);
                    end
                end
            end
            if (state_reg == lcs_pkg::ST_TWAIT)
            begin
                case (td)
                    lcs_pkg::DIR_MATCH:
                    begin
                        tn_reg <= tn_reg + LW'(1);
                        ti_reg <= ti_reg - LW'(1);
                        tj_reg <= tj_reg - LW'(1);
                    end
                    lcs_pkg::DIR_LEFT: tj_reg <= tj_reg - LW'(1);
                    default:           ti_reg <= ti_reg - LW'(1);
                endcase
            end
            if (state_reg == lcs_pkg::ST_EMIT)
            begin
                if (tn_reg == '0)
                begin
                    valid     <= 1'b1;
                    last      <= 1'b1;
                    empty_res <= 1'b1;
                    overflow  <= ovf_reg;
                end
                else
                begin
                    emit_reg <= 1'b1;
                    ek_reg   <= ek_reg + LW'(1);
                end
                if (state_next == lcs_pkg::ST_IDLE)
                begin
                    alen_reg <= '0;
                    blen_reg <= '0;
                    drop_reg <= 1'b0;
                end
            end
            if (emit_reg)
            begin
                valid     <= 1'b1;
                last      <= (ek_reg == tn_reg);
                empty_res <= 1'b0;
                overflow  <= ovf_reg;
            end
        end
    end

    // output symbol register: the result memory's read data, or zero for the empty result
    logic [7:0] sym_reg;
    always_ff @(posedge clk)
    begin
        arow_reg   <= a_rdata;
        sym_reg    <= (state_reg == lcs_pkg::ST_EMIT && tn_reg == '0) ? 8'd0 : r_rdata;
        dwaddr_reg <= {row_reg[AW-1:0], col_reg};
        dwdata_reg <= cdir[col_reg];
    end
    assign out_symbol = sym_reg;
endmodule

>>> rtl/lcs_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

>>> rtl/lcs_cell.sv
// one column cell: holds a length and a symbol of the second string
`timescale 1ns / 1ps
module lcs_cell #(
    parameter int LW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          load,
    input  logic [7:0]    load_sym,
    input  logic          step,
    input  logic          active,
    input  logic [7:0]    a_sym,
    input  logic [LW-1:0] left_len,
    input  logic [LW-1:0] diag_len,
    output logic [LW-1:0] len,
    output lcs_pkg::dir_t dir
);
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [7:0]    sym_reg;

    always_comb
    begin
        len_next = len_reg;
        dir      = lcs_pkg::DIR_LEFT;
        if (a_sym == sym_reg)
        begin
            dir      = lcs_pkg::DIR_MATCH;
            len_next = diag_len + LW'(1);
        end
        else if (left_len >= len_reg)
        begin
            len_next = left_len;
        end
        else
        begin
            dir = lcs_pkg::DIR_UP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (clear)
        begin
            len_reg <= '0;
        end
        else if (step && active)
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg <= load_sym;
        end
    end

    assign len = len_reg;
endmodule

>>> dv/tb_top.sv
// testbench for the lcs traceback core: scoreboard class, request driver, random phases
`timescale 1ns / 1ps
module tb_top;

    class lcs_scoreboard;
        byte unsigned str_a[$];
        byte unsigned str_b[$];
        bit dropped;
        byte unsigned exp_sym[$];
        bit exp_last[$];
        bit exp_empty[$];
        bit exp_ovf[$];
        int errors;

        function void note_request(lcs_pkg::cmd_t cmd, byte unsigned sym);
            int len [0:64][0:64];
            byte unsigned seq[$];
            int i;
            int j;
            if (cmd == lcs_pkg::CMD_APPEND_A) begin
                if (str_a.size() < 64) str_a = {str_a, sym};
                else dropped = 1;
            end else if (cmd == lcs_pkg::CMD_APPEND_B) begin
                if (str_b.size() < 64) str_b = {str_b, sym};
                else dropped = 1;
            end else if (cmd == lcs_pkg::CMD_COMPUTE) begin
                for (i = 0; i <= str_a.size(); i++)
                    for (j = 0; j <= str_b.size(); j++)
                        if (i == 0 || j == 0) len[i][j] = 0;
                        else if (str_a[i-1] == str_b[j-1]) len[i][j] = len[i-1][j-1] + 1;
                        else if (len[i][j-1] >= len[i-1][j]) len[i][j] = len[i][j-1];
                        else len[i][j] = len[i-1][j];
                i = str_a.size();
                j = str_b.size();
                while (i > 0 && j > 0) begin
                    if (str_a[i-1] == str_b[j-1]) begin
                        seq = {str_a[i-1], seq};
                        i--;
                        j--;
                    end else if (len[i][j-1] >= len[i-1][j]) j--;
                    else i--;
                end
                if (seq.size() == 0) begin
                    exp_sym = {exp_sym, 8'd0}; exp_last = {exp_last, 1'b1};
                    exp_empty = {exp_empty, 1'b1}; exp_ovf = {exp_ovf, dropped};
                end else begin
                    foreach (seq[k]) begin
                        exp_sym = {exp_sym, seq[k]};
                        exp_last = {exp_last, (k == seq.size() - 1)};
                        exp_empty = {exp_empty, 1'b0}; exp_ovf = {exp_ovf, dropped};
                    end
                end
                str_a.delete();
                str_b.delete();
                dropped = 0;
            end
        endfunction

        function void check_result(byte unsigned sym, bit lst, bit emp, bit ovf);
            if (exp_sym.size() == 0) begin
                $error("unexpected result sym=%0d", sym);
                errors++;
                return;
            end
            if (sym != exp_sym[0]) begin
                $error("out_symbol exp %0d got %0d", exp_sym[0], sym); errors++;
            end
            if (lst != exp_last[0]) begin
                $error("last exp %0d got %0d", exp_last[0], lst); errors++;
            end
            if (emp != exp_empty[0]) begin
                $error("empty_res exp %0d got %0d", exp_empty[0], emp); errors++;
            end
            if (ovf != exp_ovf[0]) begin
                $error("overflow exp %0d got %0d", exp_ovf[0], ovf); errors++;
            end
            void'(exp_sym.pop_front()); void'(exp_last.pop_front());
            void'(exp_empty.pop_front()); void'(exp_ovf.pop_front());
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] command;
    logic [7:0] symbol;
    logic valid;
    logic [7:0] out_symbol;
    logic last;
    logic empty_res;
    logic overflow;

    lcs_scoreboard sb;
    int idle_pct;
    int quiet_cycles = 0;

    lcs_with_traceback_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .symbol(symbol), .valid(valid),
        .out_symbol(out_symbol), .last(last), .empty_res(empty_res),
        .overflow(overflow)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (valid) sb.check_result(out_symbol, last, empty_res, overflow);
            if (start && !busy) sb.note_request(lcs_pkg::cmd_t'(command), symbol);
            if (valid || (start && !busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(lcs_pkg::cmd_t cmd, logic [7:0] sym);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            command <= lcs_pkg::cmd_t'($urandom_range(3));
            @(negedge clk);
        end
        start <= 1;
        command <= cmd;
        symbol <= sym;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pair(int la, int lb, int alpha);
        for (int k = 0; k < la; k++)
            send_request(lcs_pkg::CMD_APPEND_A, 8'($urandom_range(alpha - 1)));
        for (int k = 0; k < lb; k++)
            send_request(lcs_pkg::CMD_APPEND_B, 8'($urandom_range(alpha - 1)));
        send_request(lcs_pkg::CMD_COMPUTE, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int n;
        sb = new();
        idle_pct = 0;
        rst_n = 0;
        start = 0;
        command = lcs_pkg::CMD_NONE;
        symbol = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;

        // directed: empty strings, unused command, extreme bytes, overflow
        send_request(lcs_pkg::CMD_COMPUTE, 8'hff);
        send_request(lcs_pkg::CMD_NONE, 8'h55);
        send_request(lcs_pkg::CMD_APPEND_A, 8'h00);
        send_request(lcs_pkg::CMD_APPEND_B, 8'hff);
        send_request(lcs_pkg::CMD_COMPUTE, 8'h00);
        send_request(lcs_pkg::CMD_APPEND_A, 8'hff);
        send_request(lcs_pkg::CMD_APPEND_A, 8'h00);
        send_request(lcs_pkg::CMD_APPEND_B, 8'h00);
        send_request(lcs_pkg::CMD_APPEND_B, 8'hff);
        send_request(lcs_pkg::CMD_COMPUTE, 8'h00);
        send_request(lcs_pkg::CMD_APPEND_A, 8'haa);
        send_request(lcs_pkg::CMD_APPEND_B, 8'haa);
        send_request(lcs_pkg::CMD_NONE, 8'h00);
        send_request(lcs_pkg::CMD_COMPUTE, 8'h00);
        // full strings of one value plus drops on both sides
        for (int k = 0; k < 65; k++) send_request(lcs_pkg::CMD_APPEND_A, 8'h5a);
        for (int k = 0; k < 65; k++) send_request(lcs_pkg::CMD_APPEND_B, 8'h5a);
        send_request(lcs_pkg::CMD_COMPUTE, 8'h00);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 70 : (ph == 3) ? 7 : 0;
            n = 0;
            while (n < 16) begin
                if ($urandom_range(9) == 0) begin
                    send_request(lcs_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
                    n++;
                end else begin
                    int la, lb;
                    la = $urandom_range(0, 8);
                    lb = $urandom_range(0, 8);
                    send_pair(la, lb, ($urandom_range(1) != 0) ? 4 : 256);
                    n += la + lb + 1;
                end
            end
        end
        start <= 0;

        while (sb.exp_sym.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/lcs_pkg.sv
rtl/lcs_ram.sv
rtl/lcs_cell.sv
rtl/lcs_with_traceback_core.sv
dv/tb_top.sv
